// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HLFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HLFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/hlfr_pkg.sv
// Types and constants of the hex length frame receiver.
package hlfr_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_OVERHEAD = 2'd2;

	localparam logic [7:0] RST_HEADER_FIRST  = 8'd12;
	localparam logic [7:0] RST_HEADER_SECOND = 8'd10;
	localparam logic [3:0] RST_SIZE_OVERHEAD = 4'd5;

	// ASCII decode of a hex character
	localparam logic [15:0] HEX_DIGIT_LIMIT = 16'd58;
	localparam logic [15:0] HEX_NUM_BASE    = 16'd48;
	localparam logic [15:0] HEX_ALPHA_BASE  = 16'd55;

	// four hex characters per field, fifth size byte closes the size field
	localparam logic [2:0] HEX_CHARS = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_DATA     = 3'd1,
		EV_ACCEPT   = 3'd2,
		EV_MISMATCH = 3'd3,
		EV_ABANDON  = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_SIZE    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CHECK   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [3:0] size_overhead;
	} cfg_t;

	typedef struct packed {
		event_t     event_res;
		logic [7:0] payload_byte;
		logic       payload_last;
	} result_t;

endpackage

// File: hw/rtl/hlfr_if.sv
// Valid/ready channels of the frame receiver: received bytes in, results out.
interface hlfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlfr_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] payload_byte;
	logic       payload_last;

	modport source (output valid, output event_res, output payload_byte,
		output payload_last, input ready);
	modport sink (input valid, input event_res, input payload_byte,
		input payload_last, output ready);
endinterface

// File: hw/rtl/hlfr_cfg_regs.sv
// Configuration registers of the frame receiver.
module hlfr_cfg_regs
	import hlfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [7:0] header_first_q;
	logic [7:0] header_second_q;
	logic [3:0] size_overhead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= RST_HEADER_FIRST;
			header_second_q <= RST_HEADER_SECOND;
			size_overhead_q <= RST_SIZE_OVERHEAD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_FIRST:  header_first_q  <= cfg_data;
				CFG_HEADER_SECOND: header_second_q <= cfg_data;
				CFG_SIZE_OVERHEAD: size_overhead_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg.header_first  = header_first_q;
	assign cfg.header_second = header_second_q;
	assign cfg.size_overhead = size_overhead_q;

endmodule

// File: hw/rtl/hlfr_parser.sv
// Frame parser: phase state machine, hex decode, running sum, per-byte result.
module hlfr_parser
	import hlfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

`include "assert_macros.svh"

	phase_t      phase_q, phase_n;
	logic [2:0]  pos_q, pos_n;
	logic [7:0]  first_q, first_n;
	logic [15:0] sum_q, sum_n;
	logic [15:0] dec_q, dec_n;
	logic [15:0] rem_q, rem_n;

	logic [15:0] byte_w;
	logic [15:0] digit;
	logic [15:0] shifted;
	logic [15:0] rem_dec;

	assign byte_w  = {8'h00, rx_byte};
	assign digit   = (byte_w < HEX_DIGIT_LIMIT) ? (byte_w - HEX_NUM_BASE)
		: (byte_w - HEX_ALPHA_BASE);
	assign shifted = {dec_q[11:0], 4'h0} + digit;
	assign rem_dec = rem_q - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			first_q <= '0;
			sum_q   <= '0;
			dec_q   <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			first_q <= first_n;
			sum_q   <= sum_n;
			dec_q   <= dec_n;
			rem_q   <= rem_n;
		end
	end

	always_comb begin
		phase_n          = phase_q;
		pos_n            = pos_q;
		first_n          = first_q;
		sum_n            = sum_q;
		dec_n            = dec_q;
		rem_n            = rem_q;
		res.event_res    = EV_NONE;
		res.payload_byte = 8'h00;
		res.payload_last = 1'b0;
		case (phase_q)
			PH_SIZE: begin
				sum_n = sum_q + byte_w;
				if (pos_q < HEX_CHARS) begin
					dec_n = shifted;
					pos_n = pos_q + 3'd1;
				end else begin
					pos_n = '0;
					if (dec_q == 16'd0) begin
						res.event_res = EV_ABANDON;
						phase_n       = PH_HEADER;
						sum_n         = '0;
						dec_n         = '0;
						rem_n         = '0;
					end else begin
						rem_n   = (dec_q > {12'h000, cfg.size_overhead})
							? (dec_q - {12'h000, cfg.size_overhead}) : 16'd0;
						dec_n   = '0;
						phase_n = (rem_n != 16'd0) ? PH_PAYLOAD : PH_CHECK;
					end
				end
			end
			PH_PAYLOAD: begin
				sum_n            = sum_q + byte_w;
				rem_n            = rem_dec;
				res.event_res    = EV_DATA;
				res.payload_byte = rx_byte;
				if (rem_dec == 16'd0) begin
					res.payload_last = 1'b1;
					phase_n          = PH_CHECK;
					pos_n            = '0;
					dec_n            = '0;
				end
			end
			PH_CHECK: begin
				if (pos_q < HEX_CHARS) begin
					dec_n = shifted;
					pos_n = pos_q + 3'd1;
				end else begin
					res.event_res = (sum_q == dec_q) ? EV_ACCEPT : EV_MISMATCH;
					phase_n       = PH_HEADER;
					pos_n         = '0;
					sum_n         = '0;
					dec_n         = '0;
					rem_n         = '0;
				end
			end
			default: begin
				if (pos_q == 3'd0) begin
					first_n = rx_byte;
					pos_n   = 3'd1;
				end else if (first_q == cfg.header_first &&
					rx_byte == cfg.header_second) begin
					sum_n   = {8'h00, first_q} + byte_w;
					dec_n   = '0;
					phase_n = PH_SIZE;
					pos_n   = '0;
				end else begin
					res.event_res = EV_ABANDON;
					phase_n       = PH_HEADER;
					pos_n         = '0;
					sum_n         = '0;
					dec_n         = '0;
					rem_n         = '0;
				end
			end
		endcase
	end

	`HLFR_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= HEX_CHARS, "position counter out of range")
	`HLFR_ASSERT_NXT(a_abandon_resync, step && res.event_res == EV_ABANDON, phase_q == PH_HEADER && pos_q == 3'd0, "abandon did not return to header hunt")
	`HLFR_ASSERT_NXT(a_last_to_check, step && res.payload_last, phase_q == PH_CHECK && pos_q == 3'd0, "last payload byte did not enter checksum phase")
	`HLFR_ASSERT_IMP(a_payload_nonzero, phase_q == PH_PAYLOAD, rem_q != 16'd0, "payload phase with no bytes left")

endmodule

// File: hw/rtl/hex_length_frame_receiver.sv
// Top level of the hex length frame receiver.
//
// Usage:
//   rx  : valid/ready request channel, one received byte (rx_byte) per request.
//   res : valid/ready request channel, exactly one result per received byte:
//         event_res (none, payload byte, frame accepted, checksum mismatch,
//         frame abandoned), payload_byte and payload_last for payload bytes.
//   cfg : write port for header_first, header_second and size_overhead;
//         write only while no request is in flight.
// Path: input register, then the parser into the result register, then res.
// Throughput: one byte per cycle while res.ready is high. The parser state
//   updates in a single pass from the input register, so back-to-back
//   bytes never wait on it.
// Stall: when res.ready is low the result register holds; one more byte is
//   still taken into the input register, then rx.ready drops until res drains.
// Reset: arst_n clears both pipeline stages, puts the parser into header
//   hunt with a zero sum, and restores the register defaults 12, 10 and 5.
module hex_length_frame_receiver
	import hlfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	hlfr_byte_if.sink             rx,
	hlfr_result_if.source         res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

	cfg_t       cfg;
	result_t    step_res;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	// result register
	logic       valid_s2;
	result_t    res_s2;

	logic       adv_s2;

	hlfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// s1 byte moves into the parser when the result slot is free or draining
	assign adv_s2   = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || adv_s2;

	hlfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s2),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= step_res;
		end
	end

	assign res.valid        = valid_s2;
	assign res.event_res    = res_s2.event_res;
	assign res.payload_byte = res_s2.payload_byte;
	assign res.payload_last = res_s2.payload_last;

	`HLFR_ASSERT_IMP(a_last_is_data, res.valid && res.payload_last, res.event_res == EV_DATA, "payload_last on a non-data result")
	`HLFR_ASSERT_NXT(a_step_fills_s2, adv_s2, valid_s2, "parsed byte lost its result slot")

endmodule

// File: tb/tb.sv
// Self-checking testbench of hex_length_frame_receiver: directed frames, then random frames.
`timescale 1ns / 100ps

module tb;
	import hlfr_pkg::*;

	// Cycles with no request moving on any port before the run is called hung.
	// The longest stall expected is a run of receiver idles at 80 percent.
	localparam int unsigned STALL_LIMIT = 1000;
	// Items per random stretch; two stretches per idling mode, three modes.
	localparam int unsigned STRETCH_ITEMS = 85;

	// Idling modes: sender busy and receiver slow, then the reverse, then no idling.
	localparam int unsigned SEND_IDLE [3] = '{23, 80, 0};
	localparam int unsigned RECV_IDLE [3] = '{80, 23, 0};

	localparam result_t R_NONE     = '{EV_NONE, 8'h00, 1'b0};
	localparam result_t R_ABANDON  = '{EV_ABANDON, 8'h00, 1'b0};
	localparam result_t R_ACCEPT   = '{EV_ACCEPT, 8'h00, 1'b0};

	// One directed request; when hand_typed is set, want is checked instead of
	// the predicted result (the predictor still runs to keep its state).
	typedef struct packed {
		logic [7:0] rx_value;
		logic       hand_typed;
		result_t    want;
	} stim_row_t;

	// Directed frames, all under the reset header values 0x0C 0x0A and overhead 5.
	localparam stim_row_t DIRECTED_ROWS [34] = '{
		// good frame: size "0006" -> one payload byte, sum 0x01DB, checksum "01DB"
		'{8'h0C, 1'b1, R_NONE},
		'{8'h0A, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h36, 1'b1, R_NONE},
		'{8'h00, 1'b1, R_NONE},
		'{8'hFF, 1'b1, '{EV_DATA, 8'hFF, 1'b1}},
		'{8'h30, 1'b1, R_NONE},
		'{8'h31, 1'b1, R_NONE},
		'{8'h44, 1'b1, R_NONE},
		'{8'h42, 1'b1, R_NONE},
		'{8'h80, 1'b1, R_ACCEPT},
		// bad second header byte drops the pair
		'{8'h0C, 1'b1, R_NONE},
		'{8'h0B, 1'b1, R_ABANDON},
		// size "0000" abandons on the fifth size byte
		'{8'h0C, 1'b1, R_NONE},
		'{8'h0A, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h5A, 1'b1, R_ABANDON},
		// size equal to overhead: no payload; lowercase checksum decodes off -> mismatch
		'{8'h0C, 1'b1, R_NONE},
		'{8'h0A, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h30, 1'b1, R_NONE},
		'{8'h35, 1'b1, R_NONE},
		'{8'h7F, 1'b1, R_NONE},
		'{8'h66, 1'b0, R_NONE},
		'{8'h66, 1'b0, R_NONE},
		'{8'h66, 1'b0, R_NONE},
		'{8'h66, 1'b0, R_NONE},
		'{8'h00, 1'b0, R_NONE}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hlfr_byte_if rx_ch ();
	hlfr_result_if res_ch ();

	hex_length_frame_receiver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Register copies, updated when the write port has written them.
	logic [7:0] hdr_first = RST_HEADER_FIRST;
	logic [7:0] hdr_second = RST_HEADER_SECOND;
	logic [3:0] size_ovh = RST_SIZE_OVERHEAD;

	// Parser state of the predictor.
	phase_t      rx_phase = PH_HEADER;
	logic [2:0]  char_pos = '0;
	logic [7:0]  held_first = '0;
	logic [15:0] frame_sum = '0;
	logic [15:0] hex_acc = '0;
	logic [15:0] bytes_left = '0;

	result_t frame_events_due [$];

	int unsigned send_idle_pct = SEND_IDLE[0];
	int unsigned recv_idle_pct = RECV_IDLE[0];
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;

	// Travel with the request on rx, so the monitor knows whether the current
	// byte carries a hand-typed expectation. Driven by NBA alongside valid.
	logic    row_typed = 1'b0;
	result_t row_want = R_NONE;

	// ASCII digit value as the receiver decodes it: no check for a real hex digit,
	// 16-bit wrap for characters below '0'.
	function automatic logic [15:0] hex_value(input logic [7:0] c);
		return ({8'h00, c} < HEX_DIGIT_LIMIT) ? {8'h00, c} - HEX_NUM_BASE
			: {8'h00, c} - HEX_ALPHA_BASE;
	endfunction

	// Uppercase ASCII hex character of one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'(HEX_NUM_BASE) + {4'h0, n} : 8'(HEX_ALPHA_BASE) + {4'h0, n};
	endfunction

	task automatic hunt_header();
		rx_phase = PH_HEADER;
		char_pos = '0;
		frame_sum = '0;
		hex_acc = '0;
		bytes_left = '0;
	endtask

	// Advances the parser by one received byte and gives the result it causes.
	task automatic parse_byte(input logic [7:0] b, output result_t r);
		r = R_NONE;
		case (rx_phase)
			PH_SIZE: begin
				frame_sum = frame_sum + {8'h00, b};
				if (char_pos < HEX_CHARS) begin
					hex_acc = {hex_acc[11:0], 4'h0} + hex_value(b);
					char_pos = char_pos + 3'd1;
				end else begin
					// fifth size byte closes the size field
					char_pos = '0;
					if (hex_acc == '0) begin
						r.event_res = EV_ABANDON;
						hunt_header();
					end else begin
						bytes_left = (hex_acc > {12'h000, size_ovh})
							? hex_acc - {12'h000, size_ovh} : 16'h0000;
						hex_acc = '0;
						rx_phase = (bytes_left != '0) ? PH_PAYLOAD : PH_CHECK;
					end
				end
			end
			PH_PAYLOAD: begin
				frame_sum = frame_sum + {8'h00, b};
				bytes_left = bytes_left - 16'd1;
				r.event_res = EV_DATA;
				r.payload_byte = b;
				if (bytes_left == '0) begin
					r.payload_last = 1'b1;
					rx_phase = PH_CHECK;
					char_pos = '0;
					hex_acc = '0;
				end
			end
			PH_CHECK: begin
				// checksum characters and end byte stay out of the sum
				if (char_pos < HEX_CHARS) begin
					hex_acc = {hex_acc[11:0], 4'h0} + hex_value(b);
					char_pos = char_pos + 3'd1;
				end else begin
					r.event_res = (frame_sum == hex_acc) ? EV_ACCEPT : EV_MISMATCH;
					hunt_header();
				end
			end
			default: begin
				if (char_pos == '0) begin
					held_first = b;
					char_pos = 3'd1;
				end else if (held_first == hdr_first && b == hdr_second) begin
					frame_sum = {8'h00, held_first} + {8'h00, b};
					hex_acc = '0;
					rx_phase = PH_SIZE;
					char_pos = '0;
				end else begin
					r.event_res = EV_ABANDON;
					hunt_header();
				end
			end
		endcase
	endtask

	// Offers one byte on rx, idling first at the sender's rate, and returns at the
	// edge where it is taken. valid stays high into the next call.
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
		input result_t want = R_NONE);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Stops offering bytes and waits until every predicted result has come out.
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (frame_events_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// All three registers in back-to-back cycles, write enable held high.
	task automatic write_config(input logic [7:0] first_val, input logic [7:0] second_val,
		input logic [3:0] ovh_val);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEADER_FIRST;
		cfg_data <= first_val;
		@(posedge clk);
		cfg_index <= CFG_HEADER_SECOND;
		cfg_data <= second_val;
		@(posedge clk);
		cfg_index <= CFG_SIZE_OVERHEAD;
		cfg_data <= CFG_DATA_W'(ovh_val);
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_first = first_val;
		hdr_second = second_val;
		size_ovh = ovh_val;
	endtask

	// One frame with a matching header and random content. Mostly small sizes,
	// some zero or within the overhead, a few large; now and then an odd last
	// size character, a wrong checksum or junk checksum characters.
	// With reconfig set, the registers change between the fourth and fifth size
	// byte, so the new overhead decides the payload length.
	task automatic send_frame(input logic reconfig, input logic [7:0] new_first,
		input logic [7:0] new_second, input logic [3:0] new_ovh);
		logic [15:0] size_val;
		logic [15:0] decoded;
		logic [15:0] sum;
		logic [15:0] crc;
		logic [7:0]  c;
		int unsigned pick;
		int unsigned n_payload;
		sum = {8'h00, hdr_first} + {8'h00, hdr_second};
		decoded = '0;
		send_byte(hdr_first);
		send_byte(hdr_second);
		pick = $urandom_range(99);
		if (pick < 8)
			size_val = '0;
		else if (pick < 25)
			size_val = 16'($urandom_range(size_ovh, 1));
		else if (pick < 95)
			size_val = {12'h000, size_ovh} + 16'($urandom_range(12, 1));
		else
			size_val = {12'h000, size_ovh} + 16'($urandom_range(60, 13));
		for (int i = 0; i < 4; i++) begin
			c = hex_char(size_val[15:12]);
			size_val = size_val << 4;
			// odd last character: ':' up to 'z', decodes to at most 67
			if (i == 3 && $urandom_range(9) == 0)
				c = 8'($urandom_range(122, 58));
			decoded = {decoded[11:0], 4'h0} + hex_value(c);
			sum = sum + {8'h00, c};
			send_byte(c);
		end
		if (reconfig) begin
			settle();
			write_config(new_first, new_second, new_ovh);
		end
		c = 8'($urandom_range(255));
		sum = sum + {8'h00, c};
		send_byte(c);
		if (decoded == '0)
			return;
		n_payload = (decoded > {12'h000, size_ovh}) ? int'(decoded - {12'h000, size_ovh}) : 0;
		repeat (n_payload) begin
			c = 8'($urandom_range(255));
			sum = sum + {8'h00, c};
			send_byte(c);
		end
		crc = sum;
		if ($urandom_range(9) == 0)
			crc = crc ^ 16'($urandom_range(65535, 1));
		repeat (4) begin
			c = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : hex_char(crc[15:12]);
			crc = crc << 4;
			send_byte(c);
		end
		send_byte(8'($urandom_range(255)));
	endtask

	// Receiver side: ready toggles at random at the current idle rate.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Predict on every accepted byte, then check every accepted result against
	// the oldest prediction. Prediction goes first so the order is fixed.
	always @(posedge clk) begin : monitor
		result_t predicted;
		result_t want;
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				parse_byte(rx_ch.rx_byte, predicted);
				frame_events_due.push_back(row_typed ? row_want : predicted);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (frame_events_due.size() == 0) begin
					$error("result with nothing pending: event_res %0d", res_ch.event_res);
					mismatches++;
				end else begin
					want = frame_events_due.pop_front();
					if (res_ch.event_res !== want.event_res) begin
						$error("event_res: expected %0d, actual %0d", want.event_res,
							res_ch.event_res);
						mismatches++;
					end
					if (res_ch.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %0h, actual %0h", want.payload_byte,
							res_ch.payload_byte);
						mismatches++;
					end
					if (res_ch.payload_last !== want.payload_last) begin
						$error("payload_last: expected %0b, actual %0b", want.payload_last,
							res_ch.payload_last);
						mismatches++;
					end
				end
			end
		end
	end

	// Hang detector: any request on rx, res or the write port restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned target;
		int unsigned pick;
		logic [7:0]  nf;
		logic [7:0]  ns;
		logic [3:0]  nov;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HEADER_FIRST;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset register values.
		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].rx_value, DIRECTED_ROWS[i].hand_typed,
				DIRECTED_ROWS[i].want);

		// Random frames: per idling mode one stretch at extreme register values,
		// one at random values. Each stretch opens with a frame that carries the
		// register change in its size field.
		for (int m = 0; m < 3; m++) begin
			send_idle_pct = SEND_IDLE[m];
			recv_idle_pct = RECV_IDLE[m];
			for (int s = 0; s < 2; s++) begin
				if (s == 1) begin
					nf = 8'($urandom_range(255));
					ns = 8'($urandom_range(255));
					nov = 4'($urandom_range(15));
				end else if (m == 0) begin
					nf = 8'h00; ns = 8'hFF; nov = 4'h0;
				end else if (m == 1) begin
					nf = 8'hFF; ns = 8'h00; nov = 4'hF;
				end else begin
					nf = 8'h00; ns = 8'h00; nov = 4'hF;
				end
				send_frame(1'b1, nf, ns, nov);
				target = bytes_sent + STRETCH_ITEMS;
				while (bytes_sent < target) begin
					pick = $urandom_range(99);
					if (pick < 72) begin
						send_frame(1'b0, 8'h00, 8'h00, 4'h0);
					end else if (pick < 86) begin
						// right first byte, wrong second
						send_byte(hdr_first);
						send_byte(hdr_second ^ 8'($urandom_range(255, 1)));
					end else begin
						// wrong first byte, anything after it
						send_byte(hdr_first ^ 8'($urandom_range(255, 1)));
						send_byte(8'($urandom_range(255)));
					end
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: hex_length_frame_receiver.f
+incdir+hw/rtl
hw/rtl/hlfr_pkg.sv
hw/rtl/hlfr_if.sv
hw/rtl/hlfr_cfg_regs.sv
hw/rtl/hlfr_parser.sv
hw/rtl/hex_length_frame_receiver.sv
tb/tb.sv
